### rtl/core/box_downsample_2x2_macros.svh
// Assertion macros shared by the downsampler RTL.
// Each macro takes a label, the clock, the active-low reset and the two
// sides of the implication.
`ifndef BOX_DOWNSAMPLE_2X2_MACROS_SVH
`define BOX_DOWNSAMPLE_2X2_MACROS_SVH

// Same-cycle implication.
`define BDS_ASSERT_IMPL(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("Same-cycle check failed in the downsampler.");

// Next-cycle implication.
`define BDS_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("Next-cycle check failed in the downsampler.");

`endif

### rtl/core/bds_pkg.sv
`default_nettype none

package bds_pkg;

	// Pixel layout: four 8-bit channels, red first.
	localparam int NUM_CH = 4;
	localparam int CH_W   = 8;
	// A horizontal pair sum needs one bit more than a channel.
	localparam int PAIR_W = CH_W + 1;
	// A full 2x2 sum needs two bits more than a channel.
	localparam int SUM_W  = CH_W + 2;

	// Configuration register indexes.
	typedef logic [0:0] bds_reg_idx_t;
	localparam bds_reg_idx_t REG_SRC_WIDTH  = 1'b0;
	localparam bds_reg_idx_t REG_SRC_HEIGHT = 1'b1;

	localparam int SRC_WIDTH_W  = 13;
	localparam int SRC_HEIGHT_W = 16;

	typedef logic [NUM_CH-1:0][PAIR_W-1:0] bds_pair_t;
	typedef logic [NUM_CH-1:0][CH_W-1:0]   bds_pixel_t;

	// Control that travels with a pixel that produces a result.
	typedef struct packed {
		logic odd_row;   // block completes a pair sum stored from the row above
		logic two_cols;  // horizontal pair holds two pixels
		logic row_end;
		logic frame_end;
	} bds_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/bds_line_mem.sv
`default_nettype none

module bds_line_mem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 36
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/core/box_downsample_2x2.sv
// 2x2 box-filter downsampler for mipmap generation.
// Input channel: one RGBA8888 source pixel per transaction in raster order,
// accepted when in_valid is high and in_stall is low. Output channel: one
// averaged pixel per 2x2 source block with row_end and frame_end marks,
// taken when out_valid is high and out_stall is low.
// Width and height must be written over the APB port only while idle; the
// block does not check it. Any write restarts the frame at the top-left pixel.
// Throughput is one source pixel per clock while in_stall is low. A result
// passes the first stage, which holds the line store read and the pair sums,
// and then the output register, which holds the average.
// The line store has one write and one read port, used in even and odd rows
// respectively, so no pixel waits for it.
// While the receiver stalls, the output holds and one further result can wait
// in the first stage; after that in_stall rises. Pixels that produce no
// result are still taken while the first stage is free.
// Reset clears the counters, the held pixel and all valid flags and sets
// both dimensions to 1. The line store has no clearing pass, as every entry
// is written in an even row before the odd row below reads it.
`default_nettype none

module box_downsample_2x2 #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Source pixels
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_red,
	input  wire logic [7:0]  in_green,
	input  wire logic [7:0]  in_blue,
	input  wire logic [7:0]  in_alpha,
	// Destination pixels
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  out_red,
	output logic      [7:0]  out_green,
	output logic      [7:0]  out_blue,
	output logic      [7:0]  out_alpha,
	output logic             row_end,
	output logic             frame_end
);

`include "box_downsample_2x2_macros.svh"

	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int XW         = $clog2(MAX_WIDTH);
	localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int DW         = $bits(bds_pkg::bds_pair_t);

	// Configuration registers and counters.
	logic [bds_pkg::SRC_WIDTH_W-1:0]  src_width_q;
	logic [bds_pkg::SRC_HEIGHT_W-1:0] src_height_q;
	logic [XW-1:0]                    col_q;
	logic [bds_pkg::SRC_HEIGHT_W-1:0] row_q;
	bds_pkg::bds_pixel_t              held_q;

	logic                             cfg_wr;
	logic [31:0]                      w_eff;
	logic [XW-1:0]                    last_x;
	logic [bds_pkg::SRC_HEIGHT_W-1:0] last_y;

	// Front end.
	bds_pkg::bds_pixel_t px;
	bds_pkg::bds_pair_t  pair;
	logic                accept;
	logic                x_odd;
	logic                y_odd;
	logic                at_last_x;
	logic                at_last_y;
	logic                has_pair;
	logic                produce;
	logic                mem_we;
	logic                mem_re;
	logic [XW:0]         col_ext;
	logic [AW-1:0]       slot;
	logic [DW-1:0]       line_rd;

	// Pipeline.
	logic                valid_s1;
	bds_pkg::bds_pair_t  pair_s1;
	bds_pkg::bds_ctrl_t  ctrl_s1;
	bds_pkg::bds_pair_t  line_s1;
	logic                out_load;
	logic                valid_s2;
	bds_pkg::bds_pixel_t avg_s2;
	logic                row_end_s2;
	logic                frame_end_s2;

	// Rounded average of one channel over 1, 2 or 4 pixels.
	function automatic logic [bds_pkg::CH_W-1:0] box_avg(
		input logic [bds_pkg::PAIR_W-1:0] pair_sum,
		input logic [bds_pkg::PAIR_W-1:0] line_sum,
		input logic                       odd_row,
		input logic                       two_cols
	);
		logic [bds_pkg::SUM_W-1:0] total;
		logic [bds_pkg::SUM_W-1:0] rounded;
		logic [1:0]                shift;
		total = {1'b0, pair_sum} + (odd_row ? {1'b0, line_sum} : '0);
		shift = {1'b0, odd_row} + {1'b0, two_cols};
		case (shift)
			2'd2:    rounded = (total + bds_pkg::SUM_W'(2)) >> 2;
			2'd1:    rounded = (total + bds_pkg::SUM_W'(1)) >> 1;
			default: rounded = total;
		endcase
		return rounded[bds_pkg::CH_W-1:0];
	endfunction

	// Register port: always ready, written in the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (paddr[2])
			bds_pkg::REG_SRC_WIDTH:  prdata = 32'(src_width_q);
			bds_pkg::REG_SRC_HEIGHT: prdata = 32'(src_height_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= bds_pkg::SRC_WIDTH_W'(1);
			src_height_q <= bds_pkg::SRC_HEIGHT_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				bds_pkg::REG_SRC_WIDTH:  src_width_q  <= pwdata[bds_pkg::SRC_WIDTH_W-1:0];
				bds_pkg::REG_SRC_HEIGHT: src_height_q <= pwdata[bds_pkg::SRC_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective dimensions: zero acts as one, the width is clamped to the line store.
	always_comb begin
		if (src_width_q == '0) begin
			w_eff = 32'd1;
		end else if (32'(src_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = 32'(MAX_WIDTH);
		end else begin
			w_eff = 32'(src_width_q);
		end
	end

	assign last_x = XW'(w_eff - 32'd1);
	assign last_y = (src_height_q == '0) ? '0 : src_height_q - bds_pkg::SRC_HEIGHT_W'(1);

	// Position decode for the incoming pixel.
	assign px        = {in_alpha, in_blue, in_green, in_red};
	assign x_odd     = col_q[0];
	assign y_odd     = row_q[0];
	assign at_last_x = (col_q == last_x);
	assign at_last_y = (row_q == last_y);
	assign has_pair  = x_odd | at_last_x;
	assign produce   = has_pair & (y_odd | at_last_y);

	assign in_stall = valid_s1 & ~out_load;
	assign accept   = in_valid & ~in_stall;

	// Horizontal pair sums: the held even pixel plus this one, or this one alone.
	always_comb begin
		for (int c = 0; c < bds_pkg::NUM_CH; c++) begin
			pair[c] = {1'b0, px[c]} + (x_odd ? {1'b0, held_q[c]} : '0);
		end
	end

	// Even rows above the last store pair sums, odd rows read them back.
	assign col_ext = {1'b0, col_q};
	assign slot    = col_ext[AW:1];
	assign mem_we  = accept & has_pair & ~y_odd & ~at_last_y;
	assign mem_re  = accept & has_pair & y_odd;

	bds_line_mem #(
		.DEPTH (LINE_DEPTH),
		.AW    (AW),
		.DW    (DW)
	) u_line_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (slot),
		.wr_data (pair),
		.rd_en   (mem_re),
		.rd_addr (slot),
		.rd_data (line_rd)
	);

	assign line_s1 = line_rd;

	// Position counters and the held even-column pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (!x_odd && !at_last_x) begin
				held_q <= px;
			end
			if (at_last_x) begin
				col_q <= '0;
				row_q <= at_last_y ? '0 : row_q + bds_pkg::SRC_HEIGHT_W'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// First stage: pair sums and control of a pixel that completes a block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= produce;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pair_s1           <= pair;
			ctrl_s1.odd_row   <= y_odd;
			ctrl_s1.two_cols  <= x_odd;
			ctrl_s1.row_end   <= at_last_x;
			ctrl_s1.frame_end <= at_last_x & at_last_y;
		end
	end

	// Output register: loads when empty or when its transaction is taken.
	assign out_load = valid_s1 & (~valid_s2 | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_load) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int c = 0; c < bds_pkg::NUM_CH; c++) begin
				avg_s2[c] <= box_avg(pair_s1[c], line_s1[c], ctrl_s1.odd_row,
					ctrl_s1.two_cols);
			end
			row_end_s2   <= ctrl_s1.row_end;
			frame_end_s2 <= ctrl_s1.frame_end;
		end
	end

	assign out_valid = valid_s2;
	assign out_red   = avg_s2[0];
	assign out_green = avg_s2[1];
	assign out_blue  = avg_s2[2];
	assign out_alpha = avg_s2[3];
	assign row_end   = row_end_s2;
	assign frame_end = frame_end_s2;

	// The line store is never written and read by the same pixel.
	`BDS_ASSERT_IMPL(a_line_port_excl, clk, arst_n, mem_we, !mem_re)
	// The column counter never runs past the last column of the frame.
	`BDS_ASSERT_IMPL(a_col_in_range, clk, arst_n, 1'b1, col_q <= last_x)
	// A register write restarts the frame.
	`BDS_ASSERT_NEXT(a_cfg_restart, clk, arst_n, cfg_wr, (col_q == '0) && (row_q == '0))
	// The last pixel of the frame also ends its row.
	`BDS_ASSERT_IMPL(a_frame_row_end, clk, arst_n, valid_s2 && frame_end_s2, row_end_s2)

endmodule

`default_nettype wire

### test/tb_box_downsample_2x2.sv
`timescale 1ns / 100ps

module tb_box_downsample_2x2;

	localparam int LINE_SLOTS  = 2048;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_PIXELS = 380;

	// One destination pixel as the block should deliver it.
	typedef struct packed {
		bds_pkg::bds_pixel_t px;
		logic                row_end;
		logic                frame_end;
	} block_avg_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_red = '0;
	logic [7:0]  in_green = '0;
	logic [7:0]  in_blue = '0;
	logic [7:0]  in_alpha = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic [7:0]  out_alpha;
	logic        row_end;
	logic        frame_end;

	box_downsample_2x2 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.in_alpha  (in_alpha),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.out_alpha (out_alpha),
		.row_end   (row_end),
		.frame_end (frame_end)
	);

	// Stimulus and expectation stores.
	bds_pkg::bds_pixel_t src_pixel_q [$];
	block_avg_t          avg_expect_q [$];

	// Predictor state: configuration, position, held pixel and pair-sum line.
	logic [bds_pkg::SRC_WIDTH_W-1:0]  cfg_width = 1;
	logic [bds_pkg::SRC_HEIGHT_W-1:0] cfg_height = 1;
	int unsigned                      col_pos = 0;
	int unsigned                      row_pos = 0;
	bds_pkg::bds_pixel_t              held_px = '0;
	bds_pkg::bds_pair_t               pair_line [0:LINE_SLOTS-1];

	int   src_idle_pct = 15;
	int   sink_idle_pct = 49;
	logic src_taken = 1'b0;
	logic long_hold_req = 1'b0;
	int   hold_left = 0;
	int   fail_count = 0;
	int   cycle_count = 0;

	always #5 clk = ~clk;

	// Append one source pixel to the pending stimulus.
	task automatic add_pixel(input bds_pkg::bds_pixel_t px);
		src_pixel_q.insert(src_pixel_q.size(), px);
	endtask

	// Work out the destination pixel, if any, that one source pixel causes.
	task automatic predict_downsample(input bds_pkg::bds_pixel_t px);
		int unsigned w;
		int unsigned h;
		int unsigned hcount;
		int unsigned count;
		int unsigned shift;
		int unsigned slot;
		int unsigned total;
		int unsigned pair_sum [bds_pkg::NUM_CH];
		block_avg_t  res;
		int          c;
		w = (cfg_width == 0) ? 1 : (cfg_width > 4096) ? 4096 : cfg_width;
		h = (cfg_height == 0) ? 1 : cfg_height;
		hcount = 0;
		if (col_pos[0]) begin
			for (c = 0; c < bds_pkg::NUM_CH; c++)
				pair_sum[c] = held_px[c] + px[c];
			hcount = 2;
		end else if (col_pos == w - 1) begin
			for (c = 0; c < bds_pkg::NUM_CH; c++)
				pair_sum[c] = px[c];
			hcount = 1;
		end else begin
			held_px = px;
		end
		if (hcount != 0) begin
			slot = (col_pos >> 1) % LINE_SLOTS;
			if (!row_pos[0] && row_pos != h - 1) begin
				// An even row above the last only stores its pair sums.
				for (c = 0; c < bds_pkg::NUM_CH; c++)
					pair_line[slot][c] = pair_sum[c][bds_pkg::PAIR_W-1:0];
			end else begin
				count = row_pos[0] ? 2 * hcount : hcount;
				shift = (count == 4) ? 2 : (count == 2) ? 1 : 0;
				for (c = 0; c < bds_pkg::NUM_CH; c++) begin
					total = pair_sum[c] + (row_pos[0] ? pair_line[slot][c] : 0);
					res.px[c] = 8'((total + count / 2) >> shift);
				end
				res.row_end = (col_pos == w - 1);
				res.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
				avg_expect_q.insert(avg_expect_q.size(), res);
			end
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Monitor: predict on each accepted source transaction, check each result.
	always @(posedge clk) begin
		block_avg_t want;
		if (arst_n) begin
			src_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				predict_downsample({in_alpha, in_blue, in_green, in_red});
			if (out_valid && !out_stall) begin
				if (avg_expect_q.size() == 0) begin
					$error("destination pixel with no expectation waiting");
					fail_count++;
				end else begin
					want = avg_expect_q.pop_front();
					check_field("out_red", want.px[0], out_red);
					check_field("out_green", want.px[1], out_green);
					check_field("out_blue", want.px[2], out_blue);
					check_field("out_alpha", want.px[3], out_alpha);
					check_field("row_end", want.row_end, row_end);
					check_field("frame_end", want.frame_end, frame_end);
				end
			end
		end
	end

	// Driver: offer the next pending pixel once the previous one has gone.
	always @(negedge clk) begin
		bds_pkg::bds_pixel_t item;
		if (!in_valid || src_taken) begin
			if (src_pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				item = src_pixel_q.pop_front();
				in_valid <= 1'b1;
				in_red <= item[0];
				in_green <= item[1];
				in_blue <= item[2];
				in_alpha <= item[3];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off when requested.
	always @(negedge clk) begin
		if (long_hold_req && hold_left == 0) begin
			hold_left = 250;
			long_hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_idle_pct);
		end
	end

	// Watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_box_downsample_2x2: FAIL");
		$finish;
	end

	task automatic write_reg(input bds_pkg::bds_reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == bds_pkg::REG_SRC_WIDTH)
			cfg_width = value[bds_pkg::SRC_WIDTH_W-1:0];
		else
			cfg_height = value[bds_pkg::SRC_HEIGHT_W-1:0];
		// Any register write restarts the frame.
		col_pos = 0;
		row_pos = 0;
	endtask

	task automatic set_frame(input int w, input int h);
		write_reg(bds_pkg::REG_SRC_WIDTH, w);
		write_reg(bds_pkg::REG_SRC_HEIGHT, h);
	endtask

	// Wait until every pixel is taken and every result has arrived, then let
	// the pipeline drain pixels that cause no result.
	task automatic wait_idle();
		while (src_pixel_q.size() != 0 || in_valid || avg_expect_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic bds_pkg::bds_pixel_t random_pixel();
		bds_pkg::bds_pixel_t px;
		int                  c;
		for (c = 0; c < bds_pkg::NUM_CH; c++) begin
			case ($urandom_range(7))
				0: px[c] = 8'd0;
				1: px[c] = 8'd255;
				default: px[c] = 8'($urandom_range(255));
			endcase
		end
		return px;
	endfunction

	task automatic queue_random(input int n);
		int i;
		for (i = 0; i < n; i++)
			add_pixel(random_pixel());
	endtask

	initial begin
		int w;
		int h;
		int n;
		int random_count;
		logic hold_used;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset dimensions are 1x1: every pixel comes straight back.
		add_pixel({8'd0, 8'd0, 8'd0, 8'd0});
		add_pixel({8'd255, 8'd255, 8'd255, 8'd255});
		add_pixel({8'h55, 8'haa, 8'h0f, 8'hf0});
		add_pixel({8'h80, 8'h01, 8'hfe, 8'h7f});
		wait_idle();

		// A 3x3 frame gives a full block, both odd edges and the corner.
		set_frame(3, 3);
		add_pixel({8'd255, 8'd255, 8'd0, 8'd1});
		add_pixel({8'd254, 8'd255, 8'd0, 8'd1});
		add_pixel({8'd7, 8'd0, 8'd128, 8'd255});
		add_pixel({8'd255, 8'd255, 8'd1, 8'd0});
		add_pixel({8'd255, 8'd254, 8'd0, 8'd0});
		add_pixel({8'd8, 8'd1, 8'd127, 8'd0});
		add_pixel({8'd0, 8'd3, 8'd0, 8'd255});
		add_pixel({8'd0, 8'd2, 8'd255, 8'd254});
		add_pixel({8'd9, 8'd9, 8'd9, 8'd9});
		wait_idle();

		// A single row: horizontal pairs only, rounding half up.
		set_frame(2, 1);
		add_pixel({8'd255, 8'd0, 8'd1, 8'd255});
		add_pixel({8'd0, 8'd255, 8'd2, 8'd0});
		wait_idle();

		// Size extremes: the widest row, a clamped width with zero height,
		// and the tallest frame.
		set_frame(4096, 1);
		queue_random(40);
		wait_idle();
		set_frame(8191, 0);
		queue_random(40);
		wait_idle();
		set_frame(1, 65535);
		queue_random(40);
		wait_idle();

		// Random frames in three idling regimes.
		random_count = 0;
		hold_used = 1'b0;
		while (random_count < RANDOM_PIXELS || !hold_used) begin
			if (random_count < RANDOM_PIXELS / 3) begin
				src_idle_pct = 15;
				sink_idle_pct = 49;
			end else if (random_count < 2 * RANDOM_PIXELS / 3) begin
				src_idle_pct = 49;
				sink_idle_pct = 15;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			case ($urandom_range(9))
				0: w = 0;
				1: w = $urandom_range(48, 11);
				default: w = $urandom_range(10, 1);
			endcase
			case ($urandom_range(9))
				0: h = 0;
				1: h = 65535;
				default: h = $urandom_range(8, 1);
			endcase
			if (h == 65535)
				n = $urandom_range(60, 10);
			else
				n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * $urandom_range(3, 1);
			if ($urandom_range(3) == 0)
				n = $urandom_range(n, 1);
			if (n > 200)
				n = $urandom_range(200, 1);
			if (!hold_used && src_idle_pct == 0) begin
				// Long receiver hold-off while a busy frame keeps coming.
				w = 6;
				h = 8;
				n = 144;
				hold_used = 1'b1;
			end
			set_frame(w, h);
			if (hold_used && n == 144 && w == 6 && h == 8)
				long_hold_req = 1'b1;
			queue_random(n);
			random_count += n;
			wait_idle();
		end

		if (fail_count == 0)
			$display("tb_box_downsample_2x2: PASS");
		else
			$display("tb_box_downsample_2x2: FAIL");
		$finish;
	end

endmodule

### box_downsample_2x2.f
+incdir+rtl/core
rtl/core/bds_pkg.sv
rtl/core/bds_line_mem.sv
rtl/core/box_downsample_2x2.sv
test/tb_box_downsample_2x2.sv
